@@ src/dcm_pkg.sv @@
`default_nettype none

package dcm_pkg;

  localparam int MAX_DEPTH   = 6;
  localparam int COUNT_BITS  = 16;
  localparam int SYM_BITS    = 3;
  localparam int NUM_SYMS    = 5;
  localparam int IDX_BITS    = SYM_BITS * MAX_DEPTH;
  localparam int TABLE_SIZE  = 1 << IDX_BITS;
  localparam int DEPTH_W     = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SYMPOS_W    = $clog2(MAX_DEPTH);

  // Nucleotide codes.
  localparam logic [SYM_BITS-1:0] SYM_A = 3'd0;
  localparam logic [SYM_BITS-1:0] SYM_C = 3'd1;
  localparam logic [SYM_BITS-1:0] SYM_T = 3'd2;
  localparam logic [SYM_BITS-1:0] SYM_G = 3'd3;
  localparam logic [SYM_BITS-1:0] SYM_N = 3'd4;

  // Request actions.
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV   = 1'd1;

  typedef logic [IDX_BITS-1:0] ctx_t;
  typedef logic [NUM_SYMS-1:0][COUNT_BITS-1:0] entry_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    ctx_t                emit_idx;
    logic                bump;
    logic [SYM_BITS-1:0] sym;
    logic                inv_en;
    ctx_t                inv_idx;
    logic [SYM_BITS-1:0] inv_sym;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT,
    ST_BUMP
  } back_state_t;

  function automatic logic [SYM_BITS-1:0] complement(input logic [SYM_BITS-1:0] s);
    logic [SYM_BITS-1:0] r;
    unique case (s)
      SYM_A:   r = SYM_T;
      SYM_C:   r = SYM_G;
      SYM_T:   r = SYM_A;
      SYM_G:   r = SYM_C;
      default: r = SYM_N;
    endcase
    return r;
  endfunction

  function automatic ctx_t depth_mask(input logic [DEPTH_W-1:0] k);
    ctx_t m;
    m = '0;
    for (int p = 0; p < MAX_DEPTH; p++) begin
      if (p < int'(k)) m[p*SYM_BITS +: SYM_BITS] = '1;
    end
    return m;
  endfunction

  // Saturating increment of one count in an entry.
  function automatic entry_t count_inc(input entry_t e, input logic [SYM_BITS-1:0] s);
    entry_t r;
    r = e;
    for (int j = 0; j < NUM_SYMS; j++) begin
      if (int'(s) == j && e[j] != '1) r[j] = e[j] + COUNT_BITS'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/dcm_queue.sv @@
`default_nettype none

module dcm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dcm_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output dcm_pkg::cmd_t      head
);

  dcm_pkg::cmd_t                 slots [dcm_pkg::QUEUE_DEPTH];
  logic [dcm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dcm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dcm_pkg::QCNT_W-1:0]    fill;

  assign full  = (fill == dcm_pkg::QCNT_W'(dcm_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dcm_pkg::QPTR_W'(dcm_pkg::QUEUE_DEPTH - 1)) ? '0
                : wr_ptr + dcm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dcm_pkg::QPTR_W'(dcm_pkg::QUEUE_DEPTH - 1)) ? '0
                : rd_ptr + dcm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + dcm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - dcm_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dcm_front.sv @@
`default_nettype none

module dcm_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [dcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dcm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic                                action,
  input  wire logic [dcm_pkg::SYM_BITS-1:0]        symbol,
  input  wire logic [dcm_pkg::IDX_BITS-1:0]        context_index,
  input  wire logic                                clearing,
  input  wire logic                                queue_full,
  output logic                                     push,
  output dcm_pkg::cmd_t                            push_cmd
);

  logic [dcm_pkg::DEPTH_W-1:0]  depth_cfg;
  logic                         inverted_repeat;
  dcm_pkg::ctx_t                window;

  logic [dcm_pkg::DEPTH_W-1:0]  k;
  dcm_pkg::ctx_t                ctx;
  dcm_pkg::ctx_t                inv;
  logic [dcm_pkg::SYM_BITS-1:0] syms [dcm_pkg::MAX_DEPTH];
  logic                         sym_ok;

  assign item_stall = clearing || queue_full;
  assign push       = item_valid && !item_stall;
  assign sym_ok     = (symbol <= dcm_pkg::SYM_N);

  always_comb begin
    if (depth_cfg == '0) begin
      k = dcm_pkg::DEPTH_W'(1);
    end else if (int'(depth_cfg) > dcm_pkg::MAX_DEPTH) begin
      k = dcm_pkg::DEPTH_W'(dcm_pkg::MAX_DEPTH);
    end else begin
      k = depth_cfg;
    end
  end

  assign ctx = window & dcm_pkg::depth_mask(k);

  // The reverse complement puts the new symbol's complement in the oldest
  // slot and reverses and complements the remaining context symbols.
  always_comb begin
    inv = '0;
    for (int p = 0; p < dcm_pkg::MAX_DEPTH; p++) begin
      syms[p] = ctx[p*dcm_pkg::SYM_BITS +: dcm_pkg::SYM_BITS];
    end
    for (int p = 0; p < dcm_pkg::MAX_DEPTH; p++) begin
      if (p + 1 < int'(k)) begin
        inv[p*dcm_pkg::SYM_BITS +: dcm_pkg::SYM_BITS] =
          dcm_pkg::complement(syms[dcm_pkg::SYMPOS_W'(int'(k) - 2 - p)]);
      end else if (p + 1 == int'(k)) begin
        inv[p*dcm_pkg::SYM_BITS +: dcm_pkg::SYM_BITS] = dcm_pkg::complement(symbol);
      end
    end
  end

  always_comb begin
    push_cmd = '0;
    if (action == dcm_pkg::ACT_READ) begin
      push_cmd.emit_idx = context_index;
    end else begin
      push_cmd.emit_idx = ctx;
      push_cmd.bump     = sym_ok;
      push_cmd.sym      = symbol;
      push_cmd.inv_en   = sym_ok && inverted_repeat;
      push_cmd.inv_idx  = inv;
      push_cmd.inv_sym  = dcm_pkg::complement(syms[dcm_pkg::SYMPOS_W'(int'(k) - 1)]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_cfg       <= dcm_pkg::DEPTH_W'(dcm_pkg::MAX_DEPTH);
      inverted_repeat <= 1'b0;
      window          <= '0;
    end else begin
      if (cfg_write && cfg_index == dcm_pkg::REG_DEPTH) begin
        depth_cfg <= cfg_data;
      end
      if (cfg_write && cfg_index == dcm_pkg::REG_INV) begin
        inverted_repeat <= cfg_data[0];
      end
      if (push && action == dcm_pkg::ACT_COUNT && sym_ok) begin
        window <= {window[dcm_pkg::IDX_BITS-dcm_pkg::SYM_BITS-1:0], symbol};
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dcm_back.sv @@
`default_nettype none

module dcm_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            queue_empty,
  input  wire dcm_pkg::cmd_t                   head,
  output logic                                 pop,
  output logic                                 clearing,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [dcm_pkg::COUNT_BITS-1:0]       count_a,
  output logic [dcm_pkg::COUNT_BITS-1:0]       count_c,
  output logic [dcm_pkg::COUNT_BITS-1:0]       count_t,
  output logic [dcm_pkg::COUNT_BITS-1:0]       count_g,
  output logic [dcm_pkg::COUNT_BITS-1:0]       count_n
);

  dcm_pkg::entry_t        mem [dcm_pkg::TABLE_SIZE];

  dcm_pkg::back_state_t   state;
  dcm_pkg::back_state_t   state_next;
  dcm_pkg::ctx_t          clr_addr;
  dcm_pkg::cmd_t          cur;
  dcm_pkg::entry_t        rd_ctx;
  dcm_pkg::entry_t        rd_inv;
  dcm_pkg::entry_t        inv_upd;
  dcm_pkg::entry_t        inv_new;
  dcm_pkg::entry_t        bump_base;
  dcm_pkg::entry_t        out_entry;

  logic                   can_pop;
  logic                   rd_en;
  logic                   wr_en;
  dcm_pkg::ctx_t          wr_addr;
  dcm_pkg::entry_t        wr_data;
  logic                   out_load;

  assign can_pop  = !queue_empty && (!result_valid || !result_stall);
  assign inv_new  = dcm_pkg::count_inc(rd_inv, cur.inv_sym);
  // When both updates hit one entry, the second builds on the first.
  assign bump_base = (cur.inv_en && cur.inv_idx == cur.emit_idx) ? inv_upd : rd_ctx;
  assign clearing = (state == dcm_pkg::ST_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      dcm_pkg::ST_CLEAR: if (clr_addr == '1) state_next = dcm_pkg::ST_IDLE;
      dcm_pkg::ST_IDLE:  if (can_pop) state_next = dcm_pkg::ST_EMIT;
      dcm_pkg::ST_EMIT:  state_next = cur.bump ? dcm_pkg::ST_BUMP : dcm_pkg::ST_IDLE;
      dcm_pkg::ST_BUMP:  state_next = dcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = cur.emit_idx;
    wr_data  = '0;
    out_load = 1'b0;
    unique case (state)
      dcm_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      dcm_pkg::ST_IDLE: begin
        pop   = can_pop;
        rd_en = can_pop;
      end
      dcm_pkg::ST_EMIT: begin
        out_load = 1'b1;
        wr_en    = cur.inv_en;
        wr_addr  = cur.inv_idx;
        wr_data  = inv_new;
      end
      dcm_pkg::ST_BUMP: begin
        wr_en   = 1'b1;
        wr_data = dcm_pkg::count_inc(bump_base, cur.sym);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ctx <= mem[head.emit_idx];
      rd_inv <= mem[head.inv_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == dcm_pkg::ST_EMIT) begin
      inv_upd <= inv_new;
    end
    if (out_load) begin
      out_entry <= rd_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dcm_pkg::ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dcm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + dcm_pkg::IDX_BITS'(1);
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign count_a = out_entry[dcm_pkg::SYM_A];
  assign count_c = out_entry[dcm_pkg::SYM_C];
  assign count_t = out_entry[dcm_pkg::SYM_T];
  assign count_g = out_entry[dcm_pkg::SYM_G];
  assign count_n = out_entry[dcm_pkg::SYM_N];

endmodule

`default_nettype wire

@@ src/dna_context_model_counter.sv @@
// Order-k context model counter for nucleotide streams.
// Requests enter on item_valid/item_stall with action, symbol and
// context_index; a request is taken at a clock edge with item_valid high and
// item_stall low. A count request (action 0) returns the counts of the
// current context as they were before it, then, if the symbol code is at
// most N, bumps them and shifts it in; a read (action 1) returns any entry.
// Every request yields one result on result_valid/result_stall, in order.
// Configuration (context depth, inverted repeats) is written through
// cfg_write/cfg_index/cfg_data while no request is in flight.
// A taken request is queued, popped with its table reads in IDLE and its
// result registered in EMIT; a count request with a valid symbol then
// holds the table in BUMP; the single write port of the table sets this.
// A two-entry queue lets requests be taken while a result waits.
// Reset clears control state and starts a pass that zeroes the 262144
// table entries, one a cycle; item_stall stays high until the pass ends.
// A stalled result holds its counts, and the back end stops popping
// requests until the result is taken.
`default_nettype none

module dna_context_model_counter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [dcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic                               action,
  input  wire logic [dcm_pkg::SYM_BITS-1:0]       symbol,
  input  wire logic [dcm_pkg::IDX_BITS-1:0]       context_index,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic [dcm_pkg::COUNT_BITS-1:0]          count_a,
  output logic [dcm_pkg::COUNT_BITS-1:0]          count_c,
  output logic [dcm_pkg::COUNT_BITS-1:0]          count_t,
  output logic [dcm_pkg::COUNT_BITS-1:0]          count_g,
  output logic [dcm_pkg::COUNT_BITS-1:0]          count_n
);

  logic          clearing;
  logic          queue_full;
  logic          queue_empty;
  logic          push;
  logic          pop;
  dcm_pkg::cmd_t push_cmd;
  dcm_pkg::cmd_t head;

  dcm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .symbol        (symbol),
    .context_index (context_index),
    .clearing      (clearing),
    .queue_full    (queue_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  dcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  dcm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .count_a      (count_a),
    .count_c      (count_c),
    .count_t      (count_t),
    .count_g      (count_g),
    .count_n      (count_n)
  );

endmodule

`default_nettype wire

@@ src/dcm_checker.sv @@
`default_nettype none

module dcm_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         item_stall,
  input wire logic                         result_valid,
  input wire logic                         result_stall,
  input wire logic [dcm_pkg::COUNT_BITS-1:0] count_a,
  input wire logic [dcm_pkg::COUNT_BITS-1:0] count_c,
  input wire logic [dcm_pkg::COUNT_BITS-1:0] count_t,
  input wire logic [dcm_pkg::COUNT_BITS-1:0] count_g,
  input wire logic [dcm_pkg::COUNT_BITS-1:0] count_n
);

  // Reset starts the table clear: no requests taken, no result shown.
  assert property (@(posedge clk) rst |=> item_stall && !result_valid)
    else $error("block not held off after reset");

  // The clear pass is long, so requests are still refused after reset.
  assert property (@(posedge clk) rst |-> ##2 item_stall)
    else $error("requests taken during table clear");

  // A result must not appear while the table is still being cleared.
  assert property (@(posedge clk) rst |-> ##2 !result_valid)
    else $error("result shown during table clear");

  // A stalled result stays up with the same counts.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(count_a) &&
      $stable(count_c) && $stable(count_t) && $stable(count_g) && $stable(count_n))
    else $error("stalled result changed");

endmodule

bind dna_context_model_counter dcm_checker u_dcm_checker (.*);

`default_nettype wire
